[hw/rtl/aff2d_pkg.sv]
// Shared types, constants and fixed-point helpers for the 2D affine transform unit.
package aff2d_pkg;

   // Number format: signed fixed point with FRAC_BITS fraction bits in COORD_WIDTH bits.
   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;
   localparam int IO_WIDTH    = 32;
   localparam int FUNC_WIDTH  = 3;

   // Multiplier operand carries one extra bit for negated and one-minus values.
   localparam int OPND_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = OPND_WIDTH + COORD_WIDTH;
   // Up to four products are summed exactly.
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [OPND_WIDTH-1:0]  opnd_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [IO_WIDTH-1:0]    io_type;

   // Operation codes of an input item.
   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_IDENTITY  = 3'd0,
      FUNC_TRANSLATE = 3'd1,
      FUNC_SCALE     = 3'd2,
      FUNC_ROTATE    = 3'd3,
      FUNC_VERTEX    = 3'd4
   } func_type;

   // Six stored coefficients; the bottom row is always 0 0 1.
   typedef struct packed {
      coord_type a00;
      coord_type a01;
      coord_type a02;
      coord_type a10;
      coord_type a11;
      coord_type a12;
   } matrix_type;

   // A saturated value together with its overflow flag.
   typedef struct packed {
      coord_type v;
      logic      ov;
   } sat_type;

   // Coefficient update decision handed to the top level.
   typedef struct packed {
      matrix_type coeffs;
      logic       load;
      logic       ov;
      logic       clear;
   } coeff_upd_type;

   // Mapped vertex handed to the top level.
   typedef struct packed {
      io_type x;
      io_type y;
      logic   ov;
   } vert_res_type;

   localparam coord_type ONE_C = coord_type'(64'd1 << FRAC_BITS);
   localparam opnd_type  ONE_O = opnd_type'(64'd1 << FRAC_BITS);

   localparam matrix_type MAT_IDENTITY = '{
      a00: ONE_C, a01: '0, a02: '0,
      a10: '0, a11: ONE_C, a12: '0
   };

   // Sign-extends a coordinate to the accumulator width.
   function automatic sum_type ext_coord(input coord_type v);
      return {{(SUM_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
   endfunction

   // Sign-extends a coordinate to the multiplier operand width.
   function automatic opnd_type to_opnd(input coord_type v);
      return {v[COORD_WIDTH-1], v};
   endfunction

   // Exact signed product, extended to the accumulator width.
   function automatic sum_type mul(input opnd_type a, input coord_type b);
      prod_type p;
      p = a * b;
      return {{(SUM_WIDTH-PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
   endfunction

   // Saturates an accumulator value to the coordinate range.
   function automatic sat_type sat_coord(input sum_type s);
      logic [SUM_WIDTH-COORD_WIDTH:0] upper;
      logic                           fits;
      sat_type                        r;
      upper = s[SUM_WIDTH-1:COORD_WIDTH-1];
      fits  = (&upper) | ~(|upper);
      r.ov  = ~fits;
      if (fits) begin
         r.v = s[COORD_WIDTH-1:0];
      end else if (s[SUM_WIDTH-1]) begin
         r.v = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         r.v = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

   // Drops the fraction bits, rounding toward negative infinity, then saturates.
   function automatic sat_type sat_floor(input sum_type s);
      return sat_coord(s >>> FRAC_BITS);
   endfunction

   // Brings an input field into the coordinate range.
   function automatic sat_type take_input(input io_type raw);
      return sat_coord({{(SUM_WIDTH-IO_WIDTH){raw[IO_WIDTH-1]}}, raw});
   endfunction

   // Fits a coordinate onto an output field.
   function automatic io_type to_io(input coord_type v);
      sum_type e;
      e = ext_coord(v);
      return e[IO_WIDTH-1:0];
   endfunction

endpackage

[hw/rtl/affine_2d_transform_unit_core.sv]
// Top level of the 2D affine transform unit: input stage, composite state and result stage.
// Keeps a composite 2D affine transform in six Q16.16 coefficients and applies each item:
// identity, translate, scale about a point, rotate about a pivot (cosine and sine given),
// or map a vertex, which alone produces a result. An item is registered in the input
// stage, processed there by the coefficient update or the vertex mapper (each path
// holds one level of parallel multipliers), and a mapped vertex lands in the result
// register. The unit takes one item per clock unless a vertex item waits in the input
// stage on a stalled result side; the result register loads as its vertex item leaves
// the input stage and holds while the result side stalls. The overflow bit of a result
// stays set after any saturation in a matrix operation until the next identity item.
module affine_2d_transform_unit_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_func,
   input  logic signed [31:0]        req_arg_x,
   input  logic signed [31:0]        req_arg_y,
   input  logic signed [31:0]        req_pivot_x,
   input  logic signed [31:0]        req_pivot_y,
   input  logic                      req_last_vertex,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_out_x,
   output logic signed [31:0]        rsp_out_y,
   output logic                      rsp_end_of_shape,
   output logic                      rsp_overflow
);

   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   aff2d_pkg::func_type      s1_func_ff;
   aff2d_pkg::io_type        s1_arg_x_ff;
   aff2d_pkg::io_type        s1_arg_y_ff;
   aff2d_pkg::io_type        s1_pivot_x_ff;
   aff2d_pkg::io_type        s1_pivot_y_ff;
   logic                     s1_last_ff;
   aff2d_pkg::matrix_type    coeff_ff;
   aff2d_pkg::matrix_type    coeff_in;
   logic                     sticky_ff;
   logic                     sticky_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   aff2d_pkg::io_type        rsp_out_x_ff;
   aff2d_pkg::io_type        rsp_out_y_ff;
   logic                     rsp_end_ff;
   logic                     rsp_ov_ff;

   logic                     req_accept;
   logic                     out_free;
   logic                     s1_is_vertex;
   logic                     s1_adv;
   aff2d_pkg::sat_type       in_ax;
   aff2d_pkg::sat_type       in_ay;
   aff2d_pkg::sat_type       in_px;
   aff2d_pkg::sat_type       in_py;
   logic                     arg_ov;
   aff2d_pkg::coeff_upd_type upd;
   aff2d_pkg::vert_res_type  vres;

   // Handshake: the input stage empties when its item is processed.
   always_comb begin
      out_free     = ~rsp_valid_ff | ~rsp_stall;
      s1_is_vertex = (s1_func_ff == aff2d_pkg::FUNC_VERTEX);
      s1_adv       = s1_valid_ff & (~s1_is_vertex | out_free);
      req_stall    = s1_valid_ff & ~s1_adv;
      req_accept   = req_valid & ~req_stall;
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   end

   // Input fields brought into the coordinate range.
   always_comb begin
      in_ax  = aff2d_pkg::take_input(s1_arg_x_ff);
      in_ay  = aff2d_pkg::take_input(s1_arg_y_ff);
      in_px  = aff2d_pkg::take_input(s1_pivot_x_ff);
      in_py  = aff2d_pkg::take_input(s1_pivot_y_ff);
      arg_ov = in_ax.ov | in_ay.ov | in_px.ov | in_py.ov;
   end

   aff2d_coeff_update u_coeff_update (
      .func    (s1_func_ff),
      .arg_x   (in_ax.v),
      .arg_y   (in_ay.v),
      .pivot_x (in_px.v),
      .pivot_y (in_py.v),
      .arg_ov  (arg_ov),
      .coeffs  (coeff_ff),
      .upd     (upd)
   );

   aff2d_vertex_map u_vertex_map (
      .coeffs (coeff_ff),
      .vx     (in_ax.v),
      .vy     (in_ay.v),
      .in_ov  (in_ax.ov | in_ay.ov),
      .res    (vres)
   );

   // Composite state and sticky overflow follow each processed item.
   always_comb begin
      coeff_in     = coeff_ff;
      sticky_in    = sticky_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && upd.load) begin
         coeff_in = upd.coeffs;
      end
      if (s1_adv && upd.clear) begin
         sticky_in = 1'b0;
      end else if (s1_adv && upd.ov) begin
         sticky_in = 1'b1;
      end
      if (out_free) begin
         rsp_valid_in = s1_adv & s1_is_vertex;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         coeff_ff     <= aff2d_pkg::MAT_IDENTITY;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         coeff_ff     <= coeff_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input stage payload, loaded with each accepted item.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff    <= aff2d_pkg::func_type'(req_func);
         s1_arg_x_ff   <= req_arg_x;
         s1_arg_y_ff   <= req_arg_y;
         s1_pivot_x_ff <= req_pivot_x;
         s1_pivot_y_ff <= req_pivot_y;
         s1_last_ff    <= req_last_vertex;
      end
   end

   // Result payload, loaded when a vertex item is processed.
   always_ff @(posedge clock) begin
      if (s1_adv && s1_is_vertex) begin
         rsp_out_x_ff <= vres.x;
         rsp_out_y_ff <= vres.y;
         rsp_end_ff   <= s1_last_ff;
         rsp_ov_ff    <= vres.ov | sticky_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_out_x_ff;
   assign rsp_out_y        = rsp_out_y_ff;
   assign rsp_end_of_shape = rsp_end_ff;
   assign rsp_overflow     = rsp_ov_ff;

`ifndef SYNTH
   // A matrix item in the input stage never waits on the result side.
   a_matrix_no_wait: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_is_vertex) |-> s1_adv)
      else $error("matrix item held in input stage");

   // An identity item leaves the identity matrix and a clear sticky flag.
   a_identity_state: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_func_ff == aff2d_pkg::FUNC_IDENTITY)
      |=> (coeff_ff == aff2d_pkg::MAT_IDENTITY && !sticky_ff))
      else $error("identity item did not restore state");

   // A new result only comes from a processed vertex item.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_is_vertex))
      else $error("result without vertex item");

   // The sticky flag is only set by an overflowing matrix update.
   a_sticky_source: assert property (@(posedge clock) disable iff (reset)
      $rose(sticky_ff) |-> $past(s1_adv && upd.ov))
      else $error("sticky overflow set without cause");

   // A vertex mapped while the sticky flag is set reports overflow.
   a_sticky_reported: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_is_vertex && sticky_ff) |=> rsp_ov_ff)
      else $error("sticky overflow not reported");
`endif

endmodule

[hw/rtl/aff2d_coeff_update.sv]
// Next composite coefficients for identity, translate, scale and rotate items.
module aff2d_coeff_update (
   input  aff2d_pkg::func_type      func,
   input  aff2d_pkg::coord_type     arg_x,
   input  aff2d_pkg::coord_type     arg_y,
   input  aff2d_pkg::coord_type     pivot_x,
   input  aff2d_pkg::coord_type     pivot_y,
   input  logic                     arg_ov,
   input  aff2d_pkg::matrix_type    coeffs,
   output aff2d_pkg::coeff_upd_type upd
);

   logic                  is_rot;
   aff2d_pkg::opnd_type   ox;
   aff2d_pkg::opnd_type   oy;
   aff2d_pkg::opnd_type   one_minus_x;
   aff2d_pkg::opnd_type   one_minus_y;
   aff2d_pkg::opnd_type   k_a0;
   aff2d_pkg::opnd_type   k_b0;
   aff2d_pkg::opnd_type   k_a1;
   aff2d_pkg::opnd_type   k_b1;
   aff2d_pkg::opnd_type   k_e0b;
   aff2d_pkg::opnd_type   k_e1a;
   aff2d_pkg::opnd_type   k_e1b;
   aff2d_pkg::sum_type    s00;
   aff2d_pkg::sum_type    s01;
   aff2d_pkg::sum_type    s02;
   aff2d_pkg::sum_type    s10;
   aff2d_pkg::sum_type    s11;
   aff2d_pkg::sum_type    s12;
   aff2d_pkg::sat_type    n00;
   aff2d_pkg::sat_type    n01;
   aff2d_pkg::sat_type    n02;
   aff2d_pkg::sat_type    n10;
   aff2d_pkg::sat_type    n11;
   aff2d_pkg::sat_type    n12;
   aff2d_pkg::sat_type    t02;
   aff2d_pkg::sat_type    t12;
   aff2d_pkg::matrix_type mul_m;
   aff2d_pkg::matrix_type trn_m;
   logic                  mul_ov;
   logic                  trn_ov;

   // Row factors: rotation mixes both rows, scale keeps each row on its own.
   always_comb begin
      is_rot      = (func == aff2d_pkg::FUNC_ROTATE);
      ox          = aff2d_pkg::to_opnd(arg_x);
      oy          = aff2d_pkg::to_opnd(arg_y);
      one_minus_x = aff2d_pkg::ONE_O - ox;
      one_minus_y = aff2d_pkg::ONE_O - oy;
      k_a0        = ox;
      k_b0        = is_rot ? -oy : '0;
      k_a1        = is_rot ? oy : '0;
      k_b1        = is_rot ? ox : oy;
      k_e0b       = is_rot ? oy : '0;
      k_e1a       = is_rot ? one_minus_x : one_minus_y;
      k_e1b       = is_rot ? -oy : '0;
   end

   // One multiplier per term, summed exactly before the floor shift.
   always_comb begin
      s00 = aff2d_pkg::mul(k_a0, coeffs.a00) + aff2d_pkg::mul(k_b0, coeffs.a10);
      s01 = aff2d_pkg::mul(k_a0, coeffs.a01) + aff2d_pkg::mul(k_b0, coeffs.a11);
      s02 = aff2d_pkg::mul(k_a0, coeffs.a02) + aff2d_pkg::mul(k_b0, coeffs.a12)
          + aff2d_pkg::mul(one_minus_x, pivot_x) + aff2d_pkg::mul(k_e0b, pivot_y);
      s10 = aff2d_pkg::mul(k_a1, coeffs.a00) + aff2d_pkg::mul(k_b1, coeffs.a10);
      s11 = aff2d_pkg::mul(k_a1, coeffs.a01) + aff2d_pkg::mul(k_b1, coeffs.a11);
      s12 = aff2d_pkg::mul(k_a1, coeffs.a02) + aff2d_pkg::mul(k_b1, coeffs.a12)
          + aff2d_pkg::mul(k_e1a, pivot_y) + aff2d_pkg::mul(k_e1b, pivot_x);
   end

   // Floor and saturate every new coefficient.
   always_comb begin
      n00    = aff2d_pkg::sat_floor(s00);
      n01    = aff2d_pkg::sat_floor(s01);
      n02    = aff2d_pkg::sat_floor(s02);
      n10    = aff2d_pkg::sat_floor(s10);
      n11    = aff2d_pkg::sat_floor(s11);
      n12    = aff2d_pkg::sat_floor(s12);
      mul_m  = '{a00: n00.v, a01: n01.v, a02: n02.v,
                 a10: n10.v, a11: n11.v, a12: n12.v};
      mul_ov = n00.ov | n01.ov | n02.ov | n10.ov | n11.ov | n12.ov;
   end

   // Translation only touches the offset column.
   always_comb begin
      t02       = aff2d_pkg::sat_coord(aff2d_pkg::ext_coord(coeffs.a02)
                                       + aff2d_pkg::ext_coord(arg_x));
      t12       = aff2d_pkg::sat_coord(aff2d_pkg::ext_coord(coeffs.a12)
                                       + aff2d_pkg::ext_coord(arg_y));
      trn_m     = coeffs;
      trn_m.a02 = t02.v;
      trn_m.a12 = t12.v;
      trn_ov    = t02.ov | t12.ov;
   end

   // Select the update for this operation.
   always_comb begin
      upd.coeffs = coeffs;
      upd.load   = 1'b0;
      upd.ov     = 1'b0;
      upd.clear  = 1'b0;
      unique case (func)
         aff2d_pkg::FUNC_IDENTITY: begin
            upd.coeffs = aff2d_pkg::MAT_IDENTITY;
            upd.load   = 1'b1;
            upd.clear  = 1'b1;
         end
         aff2d_pkg::FUNC_TRANSLATE: begin
            upd.coeffs = trn_m;
            upd.load   = 1'b1;
            upd.ov     = arg_ov | trn_ov;
         end
         aff2d_pkg::FUNC_SCALE, aff2d_pkg::FUNC_ROTATE: begin
            upd.coeffs = mul_m;
            upd.load   = 1'b1;
            upd.ov     = arg_ov | mul_ov;
         end
         default: begin
            upd.load   = 1'b0;
         end
      endcase
   end

endmodule

[hw/rtl/aff2d_vertex_map.sv]
// Maps one vertex through the composite transform.
module aff2d_vertex_map (
   input  aff2d_pkg::matrix_type   coeffs,
   input  aff2d_pkg::coord_type    vx,
   input  aff2d_pkg::coord_type    vy,
   input  logic                    in_ov,
   output aff2d_pkg::vert_res_type res
);

   aff2d_pkg::sum_type sx;
   aff2d_pkg::sum_type sy;
   aff2d_pkg::sat_type rx;
   aff2d_pkg::sat_type ry;

   // Two products per coordinate plus the offset column scaled by one.
   always_comb begin
      sx = aff2d_pkg::mul(aff2d_pkg::to_opnd(vx), coeffs.a00)
         + aff2d_pkg::mul(aff2d_pkg::to_opnd(vy), coeffs.a01)
         + (aff2d_pkg::ext_coord(coeffs.a02) <<< aff2d_pkg::FRAC_BITS);
      sy = aff2d_pkg::mul(aff2d_pkg::to_opnd(vx), coeffs.a10)
         + aff2d_pkg::mul(aff2d_pkg::to_opnd(vy), coeffs.a11)
         + (aff2d_pkg::ext_coord(coeffs.a12) <<< aff2d_pkg::FRAC_BITS);
   end

   // Floor, saturate and fit onto the output fields.
   always_comb begin
      rx     = aff2d_pkg::sat_floor(sx);
      ry     = aff2d_pkg::sat_floor(sy);
      res.x  = aff2d_pkg::to_io(rx.v);
      res.y  = aff2d_pkg::to_io(ry.v);
      res.ov = in_ov | rx.ov | ry.ov;
   end

endmodule

[sim/tb.sv]
// Self-checking testbench for the 2D affine transform unit core.
`timescale 1ns / 100ps

module tb;

   // Wide signed accumulator, large enough to hold any sum of products exactly.
   typedef logic signed [127:0] wsum_type;

   localparam wsum_type COORD_HI = (wsum_type'(1) <<< (aff2d_pkg::COORD_WIDTH - 1)) - 1;
   localparam wsum_type COORD_LO = -COORD_HI - 1;
   localparam aff2d_pkg::coord_type VAL_MAX = 32'sh7FFF_FFFF;
   localparam aff2d_pkg::coord_type VAL_MIN = 32'sh8000_0000;
   localparam int ITEMS_TOTAL = 1400;
   localparam int CYCLE_LIMIT = 200000;

   // One mapped vertex as it leaves the block.
   typedef struct {
      aff2d_pkg::coord_type x;
      aff2d_pkg::coord_type y;
      bit                   eos;
      bit                   ov;
   } vertex_type;

   // Tracks the composite transform and the mapped vertices still due.
   class transform_scoreboard;
      wsum_type   coeff[6];
      bit         sticky;
      bit         step_ov;
      vertex_type pending[$];
      int         mismatches;
      int         vertices_checked;

      function new();
         set_identity();
         mismatches = 0;
         vertices_checked = 0;
      endfunction

      function void set_identity();
         for (int i = 0; i < 6; i++) begin
            coeff[i] = 0;
         end
         coeff[0] = wsum_type'(aff2d_pkg::ONE_C);
         coeff[4] = wsum_type'(aff2d_pkg::ONE_C);
         sticky = 1'b0;
      endfunction

      // Saturates to the coordinate range and notes any clipping.
      function wsum_type clamp_range(input wsum_type v);
         if (v > COORD_HI) begin
            step_ov = 1'b1;
            return COORD_HI;
         end
         if (v < COORD_LO) begin
            step_ov = 1'b1;
            return COORD_LO;
         end
         return v;
      endfunction

      // Drops the fraction bits toward negative infinity, then saturates.
      function wsum_type floor_clamp(input wsum_type s);
         return clamp_range(s >>> aff2d_pkg::FRAC_BITS);
      endfunction

      // Applies one accepted item to the composite and queues any mapped vertex.
      function void note_item(input logic [2:0] f, input aff2d_pkg::coord_type ax,
                              input aff2d_pkg::coord_type ay, input aff2d_pkg::coord_type px,
                              input aff2d_pkg::coord_type py, input bit last);
         wsum_type   x, y, p, q, one, r0, r1;
         wsum_type   n[6];
         vertex_type v;
         x = ax;
         y = ay;
         p = px;
         q = py;
         one = wsum_type'(aff2d_pkg::ONE_C);
         step_ov = 1'b0;
         case (f)
            aff2d_pkg::FUNC_IDENTITY: begin
               set_identity();
            end
            aff2d_pkg::FUNC_TRANSLATE: begin
               coeff[2] = clamp_range(coeff[2] + x);
               coeff[5] = clamp_range(coeff[5] + y);
               if (step_ov) sticky = 1'b1;
            end
            aff2d_pkg::FUNC_SCALE: begin
               for (int c = 0; c < 3; c++) begin
                  r0 = x * coeff[c];
                  r1 = y * coeff[3 + c];
                  if (c == 2) begin
                     r0 = r0 + (one - x) * p;
                     r1 = r1 + (one - y) * q;
                  end
                  n[c] = floor_clamp(r0);
                  n[3 + c] = floor_clamp(r1);
               end
               for (int c = 0; c < 6; c++) coeff[c] = n[c];
               if (step_ov) sticky = 1'b1;
            end
            aff2d_pkg::FUNC_ROTATE: begin
               for (int c = 0; c < 3; c++) begin
                  r0 = x * coeff[c] - y * coeff[3 + c];
                  r1 = y * coeff[c] + x * coeff[3 + c];
                  if (c == 2) begin
                     r0 = r0 + p * (one - x) + q * y;
                     r1 = r1 + q * (one - x) - p * y;
                  end
                  n[c] = floor_clamp(r0);
                  n[3 + c] = floor_clamp(r1);
               end
               for (int c = 0; c < 6; c++) coeff[c] = n[c];
               if (step_ov) sticky = 1'b1;
            end
            aff2d_pkg::FUNC_VERTEX: begin
               r0 = coeff[0] * x + coeff[1] * y + coeff[2] * one;
               r1 = coeff[3] * x + coeff[4] * y + coeff[5] * one;
               v.x = aff2d_pkg::coord_type'(floor_clamp(r0));
               v.y = aff2d_pkg::coord_type'(floor_clamp(r1));
               v.eos = last;
               v.ov = step_ov | sticky;
               pending.push_back(v);
            end
            default: begin
               // Unused codes leave the state alone and produce nothing.
            end
         endcase
      endfunction

      // Compares one accepted result with the oldest expected vertex.
      function void check_vertex(input aff2d_pkg::coord_type x, input aff2d_pkg::coord_type y,
                                 input bit eos, input bit ov);
         vertex_type v;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result x=%h y=%h eos=%b ov=%b", $time, x, y, eos, ov);
            mismatches++;
            return;
         end
         v = pending.pop_front();
         vertices_checked++;
         if (x !== v.x) begin
            $display("%0t: out_x expected %h actual %h", $time, v.x, x);
            mismatches++;
         end
         if (y !== v.y) begin
            $display("%0t: out_y expected %h actual %h", $time, v.y, y);
            mismatches++;
         end
         if (eos !== v.eos) begin
            $display("%0t: end_of_shape expected %b actual %b", $time, v.eos, eos);
            mismatches++;
         end
         if (ov !== v.ov) begin
            $display("%0t: overflow expected %b actual %b", $time, v.ov, ov);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [2:0]           req_func;
   aff2d_pkg::coord_type req_arg_x;
   aff2d_pkg::coord_type req_arg_y;
   aff2d_pkg::coord_type req_pivot_x;
   aff2d_pkg::coord_type req_pivot_y;
   logic                 req_last_vertex;
   logic                 rsp_valid;
   logic                 rsp_stall;
   aff2d_pkg::coord_type rsp_out_x;
   aff2d_pkg::coord_type rsp_out_y;
   logic                 rsp_end_of_shape;
   logic                 rsp_overflow;

   transform_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int cycles = 0;

   affine_2d_transform_unit_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_arg_x        (req_arg_x),
      .req_arg_y        (req_arg_y),
      .req_pivot_x      (req_pivot_x),
      .req_pivot_y      (req_pivot_y),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_end_of_shape (rsp_end_of_shape),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: check accepted items, then choose the stall for the next cycle.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_vertex(rsp_out_x, rsp_out_y, rsp_end_of_shape, rsp_overflow);
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Presents one item, waits until it is taken, then idles at random.
   task automatic send_item(input logic [2:0] f, input aff2d_pkg::coord_type ax,
                            input aff2d_pkg::coord_type ay, input aff2d_pkg::coord_type px,
                            input aff2d_pkg::coord_type py, input bit last);
      req_valid       <= 1'b1;
      req_func        <= f;
      req_arg_x       <= ax;
      req_arg_y       <= ay;
      req_pivot_x     <= px;
      req_pivot_y     <= py;
      req_last_vertex <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(f, ax, ay, px, py, last);
      if (f <= aff2d_pkg::FUNC_VERTEX) items_sent++;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic aff2d_pkg::coord_type small_signed(input int unsigned span);
      return aff2d_pkg::coord_type'($urandom_range(0, 2 * span))
             - aff2d_pkg::coord_type'(span);
   endfunction

   // Random words, or one of the range ends, zero and minus one, chosen at random.
   function automatic aff2d_pkg::coord_type any_value();
      case ($urandom_range(0, 5))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return 0;
         3: return -1;
         default: return aff2d_pkg::coord_type'($urandom);
      endcase
   endfunction

   // A well-formed shape: optional identity, a few transforms, then its vertices.
   task automatic send_shape();
      int                   n_ops;
      int                   n_verts;
      aff2d_pkg::coord_type sx, sy;
      real                  theta;
      if ($urandom_range(0, 1)) begin
         send_item(aff2d_pkg::FUNC_IDENTITY, any_value(), any_value(), any_value(),
                   any_value(), 1'b0);
      end
      n_ops = $urandom_range(0, 3);
      for (int i = 0; i < n_ops; i++) begin
         case ($urandom_range(0, 2))
            0: send_item(aff2d_pkg::FUNC_TRANSLATE, small_signed(1 << 24),
                         small_signed(1 << 24), any_value(), any_value(),
                         1'($urandom_range(0, 1)));
            1: begin
               sx = aff2d_pkg::coord_type'($urandom_range(16384, 196608));
               sy = aff2d_pkg::coord_type'($urandom_range(16384, 196608));
               if ($urandom_range(0, 1)) sx = -sx;
               if ($urandom_range(0, 1)) sy = -sy;
               send_item(aff2d_pkg::FUNC_SCALE, sx, sy, small_signed(1 << 22),
                         small_signed(1 << 22), 1'($urandom_range(0, 1)));
            end
            default: begin
               theta = $urandom_range(0, 35999) * (6.283185307179586 / 36000.0);
               send_item(aff2d_pkg::FUNC_ROTATE,
                         aff2d_pkg::coord_type'($rtoi($cos(theta) * 65536.0)),
                         aff2d_pkg::coord_type'($rtoi($sin(theta) * 65536.0)),
                         small_signed(1 << 22), small_signed(1 << 22),
                         1'($urandom_range(0, 1)));
            end
         endcase
      end
      n_verts = $urandom_range(1, 6);
      for (int i = 0; i < n_verts; i++) begin
         send_item(aff2d_pkg::FUNC_VERTEX, small_signed(1 << 24), small_signed(1 << 24),
                   any_value(), any_value(), i == n_verts - 1);
      end
   endtask

   // Short run of fixed cases: range ends, every code, saturation and its clearing.
   task automatic send_directed();
      send_item(aff2d_pkg::FUNC_VERTEX, aff2d_pkg::ONE_C, -aff2d_pkg::ONE_C, 0, 0, 1'b0);
      send_item(aff2d_pkg::FUNC_VERTEX, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 1'b1);
      send_item(aff2d_pkg::FUNC_VERTEX, 0, -1, -1, 0, 1'b0);
      send_item(aff2d_pkg::FUNC_TRANSLATE, VAL_MAX, VAL_MIN, 0, 0, 1'b1);
      // Pushes the offsets past the range, which makes the flag stick.
      send_item(aff2d_pkg::FUNC_TRANSLATE, 1, -1, 0, 0, 1'b0);
      send_item(aff2d_pkg::FUNC_VERTEX, 0, 0, 0, 0, 1'b1);
      send_item(aff2d_pkg::FUNC_IDENTITY, VAL_MIN, VAL_MAX, -1, 1, 1'b1);
      send_item(aff2d_pkg::FUNC_VERTEX, -1, 3, 0, 0, 1'b0);
      // Half scale, so odd negative inputs show the rounding direction.
      send_item(aff2d_pkg::FUNC_SCALE, aff2d_pkg::ONE_C >>> 1, aff2d_pkg::ONE_C >>> 1,
                0, 0, 1'b0);
      send_item(aff2d_pkg::FUNC_VERTEX, -1, -3, 0, 0, 1'b1);
      send_item(aff2d_pkg::FUNC_SCALE, 2 * aff2d_pkg::ONE_C, -3 * aff2d_pkg::ONE_C,
                10 * aff2d_pkg::ONE_C, -4 * aff2d_pkg::ONE_C, 1'b0);
      send_item(aff2d_pkg::FUNC_ROTATE, 0, aff2d_pkg::ONE_C, aff2d_pkg::ONE_C,
                2 * aff2d_pkg::ONE_C, 1'b0);
      send_item(aff2d_pkg::FUNC_VERTEX, 5 * aff2d_pkg::ONE_C, 7 * aff2d_pkg::ONE_C,
                0, 0, 1'b1);
      send_item(aff2d_pkg::FUNC_ROTATE, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, 1'b1);
      send_item(aff2d_pkg::FUNC_VERTEX, VAL_MAX, VAL_MAX, 0, 0, 1'b0);
      send_item(3'd5, any_value(), any_value(), any_value(), any_value(), 1'b1);
      send_item(3'd6, any_value(), any_value(), any_value(), any_value(), 1'b0);
      send_item(3'd7, any_value(), any_value(), any_value(), any_value(), 1'b1);
      send_item(aff2d_pkg::FUNC_VERTEX, aff2d_pkg::ONE_C, aff2d_pkg::ONE_C, 0, 0, 1'b1);
      send_item(aff2d_pkg::FUNC_IDENTITY, 0, 0, 0, 0, 1'b0);
      send_item(aff2d_pkg::FUNC_SCALE, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, 1'b0);
      send_item(aff2d_pkg::FUNC_VERTEX, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, 1'b1);
      send_item(aff2d_pkg::FUNC_IDENTITY, 0, 0, 0, 0, 1'b0);
      send_item(aff2d_pkg::FUNC_VERTEX, 32'sh0001_8000, -32'sh0002_4000, 0, 0, 1'b0);
   endtask

   // Stimulus: reset, directed cases, then three random phases of idling.
   initial begin
      int send_pct[3];
      int recv_pct[3];
      int n_noise;
      send_pct        = '{25, 47, 0};
      recv_pct        = '{47, 25, 0};
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= aff2d_pkg::FUNC_IDENTITY;
      req_arg_x       <= '0;
      req_arg_y       <= '0;
      req_pivot_x     <= '0;
      req_pivot_y     <= '0;
      req_last_vertex <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = send_pct[ph];
         recv_idle_pct = recv_pct[ph];
         if (ph == 0) send_directed();
         while (items_sent < (ph + 1) * ITEMS_TOTAL / 3) begin
            if ($urandom_range(0, 99) < 80) begin
               send_shape();
            end else begin
               n_noise = $urandom_range(1, 3);
               for (int i = 0; i < n_noise; i++) begin
                  send_item(3'($urandom_range(0, 7)), any_value(), any_value(), any_value(),
                            any_value(), 1'($urandom_range(0, 1)));
               end
            end
         end
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d items in three idling phases; %0d mapped vertices checked.",
               items_sent, board.vertices_checked);
      if (board.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
